### sv/bpq_pkg.sv
// Shared opcodes and status codes for the bucket priority queue.
// No dependencies; imported by the sequencer and the top level.
package bpq_pkg;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_NOT_OPEN = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_ALREADY  = 3'd4;

   localparam int OPCODE_W   = 2;
   localparam int PRIORITY_W = 12;
   localparam int STATUS_W   = 3;

endpackage

### sv/bucket_priority_queue_core.sv
// Bucket priority queue (Dial's queue) for an A* open set: push, remove,
// pop-best and clear, one result beat per request beat. Uses bpq_pkg, bpq_seq.
//
// One request is worked on at a time; the next is taken while a result
// waits in the output register. States wait on registered reads of the
// node-info, anchor and chain memories. Push ends after dispatch when out of
// range, after the check state when already open or when it opens an empty
// bucket, and after the check and link states when it links into a chain;
// pop ends after dispatch on an empty queue and otherwise reads the anchor
// and first node, then relinks or rescans; remove ends after its check for a
// closed node or an empty bucket, after the anchor read for the last node of
// a bucket, and otherwise walks the chain link by link. When the best bucket
// empties, the best-bucket register rescans upward one bucket per cycle.
// Clear runs a clearing pass over the node-info memory; reset runs the same
// pass and no request is taken during it. The sequencer returns to idle after
// each result, and a full output register holds the result until it leaves.
module bucket_priority_queue_core
   import bpq_pkg::*;
#(
   parameter int NUM_BUCKETS = 256,
   parameter int NUM_NODES   = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   // opcode, node_id, priority_req (lowest bit up)
   input  logic [((OPCODE_W+$clog2(NUM_NODES)+PRIORITY_W+7)/8)*8-1:0] req_tdata,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // status, popped_node, popped_priority, best_bucket (lowest bit up)
   output logic [((STATUS_W+$clog2(NUM_NODES)+2*$clog2(NUM_BUCKETS)+1+7)/8)*8-1:0]
                      rsp_tdata
);

   localparam int NW    = $clog2(NUM_NODES);
   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int RSP_F = STATUS_W + NW + 2*BW + 1;
   localparam int RSP_W = ((RSP_F + 7) / 8) * 8;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic          out_free, done;
   logic [STATUS_W-1:0] status;
   logic [NW-1:0] popped_node;
   logic [BW-1:0] popped_priority;
   logic [BW:0]   best_bucket;

   assign out_free = !rsp_valid_ff || rsp_tready;

   bpq_seq #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_NODES(NUM_NODES)) u_seq (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .opcode(req_tdata[OPCODE_W-1:0]),
      .node_id(req_tdata[OPCODE_W +: NW]),
      .priority_req(req_tdata[OPCODE_W+NW +: PRIORITY_W]),
      .out_free(out_free),
      .done(done),
      .status(status),
      .popped_node(popped_node),
      .popped_priority(popped_priority),
      .best_bucket(best_bucket)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({best_bucket, popped_priority, popped_node, status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/bpq_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
module bpq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bpq_seq.sv
// Operation sequencer: drives the chain, node-info and anchor memories,
// holds the bucket valid bits and the best-bucket register. Uses bpq_pkg, bpq_ram.
module bpq_seq
   import bpq_pkg::*;
#(
   parameter int NUM_BUCKETS = 256,
   parameter int NUM_NODES   = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [OPCODE_W-1:0]            opcode,
   input  logic [$clog2(NUM_NODES)-1:0]   node_id,
   input  logic [PRIORITY_W-1:0]          priority_req,
   input  logic                           out_free,
   output logic                           done,
   output logic [STATUS_W-1:0]            status,
   output logic [$clog2(NUM_NODES)-1:0]   popped_node,
   output logic [$clog2(NUM_BUCKETS)-1:0] popped_priority,
   output logic [$clog2(NUM_BUCKETS):0]   best_bucket
);

   localparam int NW = $clog2(NUM_NODES);
   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int IW = BW + 1;

   localparam logic [NW:0]   NN_EXT  = (NW+1)'(NUM_NODES);
   localparam logic [NW-1:0] NN_LAST = NW'(NUM_NODES - 1);
   localparam logic [BW:0]   NB_EXT  = (BW+1)'(NUM_BUCKETS);
   localparam logic [12:0]   NB_13   = 13'(NUM_BUCKETS);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_P_CHK  = 4'd2;
   localparam logic [3:0] S_P_LNK1 = 4'd3;
   localparam logic [3:0] S_P_LNK2 = 4'd4;
   localparam logic [3:0] S_R_CHK  = 4'd5;
   localparam logic [3:0] S_R_ANC  = 4'd6;
   localparam logic [3:0] S_R_WALK = 4'd7;
   localparam logic [3:0] S_Q_ANC  = 4'd8;
   localparam logic [3:0] S_Q_FRST = 4'd9;
   localparam logic [3:0] S_Q_LINK = 4'd10;
   localparam logic [3:0] S_SCAN   = 4'd11;
   localparam logic [3:0] S_CLR    = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   logic [3:0]              state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [NW-1:0]           nd_ff, nd_in;
   logic [PRIORITY_W-1:0]   pri_ff, pri_in;
   logic [BW-1:0]           b_ff, b_in;
   logic [NW-1:0]           an_ff, an_in;
   logic [NW-1:0]           snd_ff, snd_in;
   logic [NW-1:0]           prev_ff, prev_in;
   logic [NW-1:0]           step_ff, step_in;
   logic [BW:0]             scan_ff, scan_in;
   logic [NW-1:0]           clr_ff, clr_in;
   logic                    clr_rsp_ff, clr_rsp_in;
   logic [NUM_BUCKETS-1:0]  valid_ff, valid_in;
   logic [BW:0]             best_ff, best_in;
   logic [STATUS_W-1:0]     st_ff, st_in;
   logic [NW-1:0]           pn_ff, pn_in;
   logic [BW-1:0]           pp_ff, pp_in;

   logic          ch_we, ch_re;
   logic [NW-1:0] ch_waddr, ch_wdata, ch_raddr, ch_rdata;
   logic          in_we, in_re;
   logic [NW-1:0] in_waddr, in_raddr;
   logic [IW-1:0] in_wdata, in_rdata;
   logic          an_we, an_re;
   logic [BW-1:0] an_waddr, an_raddr;
   logic [NW-1:0] an_wdata, an_rdata;

   bpq_ram #(.DEPTH(NUM_NODES), .WIDTH(NW)) u_chain (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_waddr), .wr_data(ch_wdata),
      .rd_en(ch_re), .rd_addr(ch_raddr), .rd_data(ch_rdata)
   );

   // node info: {open, bucket}
   bpq_ram #(.DEPTH(NUM_NODES), .WIDTH(IW)) u_info (
      .clock(clock), .wr_en(in_we), .wr_addr(in_waddr), .wr_data(in_wdata),
      .rd_en(in_re), .rd_addr(in_raddr), .rd_data(in_rdata)
   );

   bpq_ram #(.DEPTH(NUM_BUCKETS), .WIDTH(NW)) u_anchor (
      .clock(clock), .wr_en(an_we), .wr_addr(an_waddr), .wr_data(an_wdata),
      .rd_en(an_re), .rd_addr(an_raddr), .rd_data(an_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      nd_in      = nd_ff;
      pri_in     = pri_ff;
      b_in       = b_ff;
      an_in      = an_ff;
      snd_in     = snd_ff;
      prev_in    = prev_ff;
      step_in    = step_ff;
      scan_in    = scan_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      valid_in   = valid_ff;
      best_in    = best_ff;
      st_in      = st_ff;
      pn_in      = pn_ff;
      pp_in      = pp_ff;
      ch_we = 1'b0; ch_waddr = nd_ff; ch_wdata = nd_ff;
      ch_re = 1'b0; ch_raddr = nd_ff;
      in_we = 1'b0; in_waddr = nd_ff; in_wdata = '0;
      in_re = 1'b0; in_raddr = nd_ff;
      an_we = 1'b0; an_waddr = b_ff; an_wdata = nd_ff;
      an_re = 1'b0; an_raddr = b_ff;
      done  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               op_in    = opcode;
               nd_in    = node_id;
               pri_in   = priority_req;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            st_in = ST_OK;
            pn_in = '0;
            pp_in = '0;
            case (op_ff)
               OP_PUSH: begin
                  if (13'(pri_ff) >= NB_13 || {1'b0, nd_ff} >= NN_EXT) begin
                     st_in    = ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     b_in     = pri_ff[BW-1:0];
                     in_re    = 1'b1;
                     an_re    = 1'b1;
                     an_raddr = pri_ff[BW-1:0];
                     state_in = S_P_CHK;
                  end
               end
               OP_REMOVE: begin
                  if ({1'b0, nd_ff} >= NN_EXT) begin
                     st_in    = ST_NOT_OPEN;
                     state_in = S_DONE;
                  end else begin
                     in_re    = 1'b1;
                     ch_re    = 1'b1;
                     state_in = S_R_CHK;
                  end
               end
               OP_POP: begin
                  if (best_ff >= NB_EXT || !valid_ff[best_ff[BW-1:0]]) begin
                     st_in    = ST_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     b_in     = best_ff[BW-1:0];
                     an_re    = 1'b1;
                     an_raddr = best_ff[BW-1:0];
                     state_in = S_Q_ANC;
                  end
               end
               OP_CLEAR: begin
                  valid_in   = '0;
                  best_in    = NB_EXT;
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLR;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_P_CHK: begin
            if (in_rdata[IW-1]) begin
               st_in    = ST_ALREADY;
               state_in = S_DONE;
            end else begin
               in_we    = 1'b1;
               in_wdata = {1'b1, b_ff};
               if ({1'b0, b_ff} < best_ff) begin
                  best_in = {1'b0, b_ff};
               end
               if (valid_ff[b_ff]) begin
                  an_in    = an_rdata;
                  ch_re    = 1'b1;
                  ch_raddr = an_rdata;
                  state_in = S_P_LNK1;
               end else begin
                  valid_in[b_ff] = 1'b1;
                  an_we    = 1'b1;
                  ch_we    = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_P_LNK1: begin
            // new node takes over the anchor's successor
            ch_we    = 1'b1;
            ch_wdata = ch_rdata;
            state_in = S_P_LNK2;
         end
         S_P_LNK2: begin
            ch_we    = 1'b1;
            ch_waddr = an_ff;
            state_in = S_DONE;
         end
         S_R_CHK: begin
            if (!in_rdata[IW-1]) begin
               st_in    = ST_NOT_OPEN;
               state_in = S_DONE;
            end else begin
               b_in     = in_rdata[BW-1:0];
               snd_in   = ch_rdata;
               in_we    = 1'b1;
               in_wdata = {1'b0, in_rdata[BW-1:0]};
               if (!valid_ff[in_rdata[BW-1:0]]) begin
                  state_in = S_DONE;
               end else begin
                  an_re    = 1'b1;
                  an_raddr = in_rdata[BW-1:0];
                  state_in = S_R_ANC;
               end
            end
         end
         S_R_ANC: begin
            an_in = an_rdata;
            if (snd_ff == nd_ff) begin
               valid_in[b_ff] = 1'b0;
               if ({1'b0, b_ff} == best_ff) begin
                  scan_in  = {1'b0, b_ff} + 1'b1;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               prev_in  = an_rdata;
               step_in  = '0;
               ch_re    = 1'b1;
               ch_raddr = an_rdata;
               state_in = S_R_WALK;
            end
         end
         S_R_WALK: begin
            if (ch_rdata == nd_ff) begin
               ch_we    = 1'b1;
               ch_waddr = prev_ff;
               ch_wdata = snd_ff;
               if (an_ff == nd_ff) begin
                  an_we    = 1'b1;
                  an_wdata = snd_ff;
               end
               state_in = S_DONE;
            end else if (step_ff == NN_LAST) begin
               // broken chain: leave it, node is already closed
               state_in = S_DONE;
            end else begin
               prev_in  = ch_rdata;
               step_in  = step_ff + 1'b1;
               ch_re    = 1'b1;
               ch_raddr = ch_rdata;
            end
         end
         S_Q_ANC: begin
            an_in    = an_rdata;
            ch_re    = 1'b1;
            ch_raddr = an_rdata;
            state_in = S_Q_FRST;
         end
         S_Q_FRST: begin
            snd_in   = ch_rdata;
            pn_in    = ch_rdata;
            pp_in    = b_ff;
            in_we    = 1'b1;
            in_waddr = ch_rdata;
            in_wdata = {1'b0, b_ff};
            if (ch_rdata == an_ff) begin
               valid_in[b_ff] = 1'b0;
               scan_in  = {1'b0, b_ff} + 1'b1;
               state_in = S_SCAN;
            end else begin
               ch_re    = 1'b1;
               ch_raddr = ch_rdata;
               state_in = S_Q_LINK;
            end
         end
         S_Q_LINK: begin
            ch_we    = 1'b1;
            ch_waddr = an_ff;
            ch_wdata = ch_rdata;
            state_in = S_DONE;
         end
         S_SCAN: begin
            // advance one bucket per cycle until a valid one or past end
            if (scan_ff >= NB_EXT || valid_ff[scan_ff[BW-1:0]]) begin
               best_in  = scan_ff;
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_CLR: begin
            in_we    = 1'b1;
            in_waddr = clr_ff;
            in_wdata = '0;
            if (clr_ff == NN_LAST) begin
               state_in   = clr_rsp_ff ? S_DONE : S_IDLE;
               clr_rsp_in = 1'b0;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         valid_ff   <= '0;
         best_ff    <= NB_EXT;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         valid_ff   <= valid_in;
         best_ff    <= best_in;
      end
      op_ff   <= op_in;
      nd_ff   <= nd_in;
      pri_ff  <= pri_in;
      b_ff    <= b_in;
      an_ff   <= an_in;
      snd_ff  <= snd_in;
      prev_ff <= prev_in;
      step_ff <= step_in;
      scan_ff <= scan_in;
      st_ff   <= st_in;
      pn_ff   <= pn_in;
      pp_ff   <= pp_in;
   end

   assign in_ready        = (state_ff == S_IDLE);
   assign status          = st_ff;
   assign popped_node     = pn_ff;
   assign popped_priority = pp_ff;
   assign best_bucket     = best_ff;

endmodule

### test/tb_bucket_priority_queue_core.sv
// Testbench for bucket_priority_queue_core: random and directed push, remove,
// pop and clear beats checked against a behavioral model of the bucket queue.
// Depends on bpq_pkg and the RTL of bucket_priority_queue_core.
module tb_bucket_priority_queue_core
   import bpq_pkg::*;
();

   localparam int NB = 256;
   localparam int NN = 1024;
   localparam int REQ_W = 24;
   localparam int RSP_W = 32;

   typedef struct packed {
      logic [11:0] pri;
      logic [9:0]  node;
      logic [1:0]  op;
   } req_t;

   typedef struct packed {
      logic [8:0] best;
      logic [7:0] ppri;
      logic [9:0] pnode;
      logic [2:0] status;
   } rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   bucket_priority_queue_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // queue model state
   logic [9:0] q_next [NN];
   logic       q_open [NN];
   logic [7:0] q_bucket [NN];
   logic       anc_valid [NB];
   logic [9:0] anc_node [NB];
   int         q_best;

   req_t pending_reqs[$];
   rsp_t expected_rsps[$];
   int   send_idle_pct = 15;
   int   recv_idle_pct = 56;
   int   recv_hold = 0;
   int   mismatches = 0;
   bit   sending = 0;
   bit   req_taken = 0;

   function automatic void rescan(int start);
      int b;
      b = start;
      while (b < NB && !anc_valid[b]) b++;
      q_best = b;
   endfunction

   function automatic rsp_t queue_step(req_t r);
      rsp_t o;
      int b, prev, an, nd, pri, steps;
      bit found;
      o = '0;
      nd = r.node;
      pri = r.pri;
      case (r.op)
         OP_PUSH: begin
            if (pri >= NB) o.status = ST_RANGE;
            else if (q_open[nd]) o.status = ST_ALREADY;
            else begin
               if (anc_valid[pri]) begin
                  an = anc_node[pri];
                  q_next[nd] = q_next[an];
                  q_next[an] = 10'(nd);
               end else begin
                  anc_valid[pri] = 1;
                  anc_node[pri] = 10'(nd);
                  q_next[nd] = 10'(nd);
               end
               q_open[nd] = 1;
               q_bucket[nd] = 8'(pri);
               if (pri < q_best) q_best = pri;
               o.status = ST_OK;
            end
         end
         OP_REMOVE: begin
            if (!q_open[nd]) o.status = ST_NOT_OPEN;
            else begin
               o.status = ST_OK;
               b = q_bucket[nd];
               q_open[nd] = 0;
               if (anc_valid[b]) begin
                  an = anc_node[b];
                  found = 1;
                  if (q_next[nd] == nd) anc_valid[b] = 0;
                  else begin
                     found = 0;
                     prev = an;
                     for (steps = 0; steps < NN && !found; steps++) begin
                        if (q_next[prev] == nd) found = 1;
                        else prev = q_next[prev];
                     end
                     if (found) begin
                        q_next[prev] = q_next[nd];
                        if (an == nd) anc_node[b] = q_next[nd];
                     end
                  end
                  if (found && !anc_valid[b] && b == q_best) rescan(b + 1);
               end
            end
         end
         OP_POP: begin
            if (q_best >= NB || !anc_valid[q_best]) o.status = ST_EMPTY;
            else begin
               b = q_best;
               an = anc_node[b];
               prev = q_next[an];
               if (prev == an) anc_valid[b] = 0;
               else q_next[an] = q_next[prev];
               q_open[prev] = 0;
               o.status = ST_OK;
               o.pnode = 10'(prev);
               o.ppri = 8'(b);
               if (!anc_valid[b]) rescan(b + 1);
            end
         end
         default: begin
            for (int i = 0; i < NN; i++) q_open[i] = 0;
            for (int i = 0; i < NB; i++) anc_valid[i] = 0;
            q_best = NB;
            o.status = ST_OK;
         end
      endcase
      o.best = 9'(q_best);
      return o;
   endfunction

   // driver: hold a beat until it was taken, then offer the next
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_tvalid && !req_taken)) begin
            if (sending && pending_reqs.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= pending_reqs.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // monitor: record accepted requests, check result beats
   always @(posedge clock) begin
      rsp_t got, want;
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(queue_step(req_t'(req_tdata)));
         req_taken = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_t'(rsp_tdata[29:0]);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d node=%0d pri=%0d best=%0d, %s",
                     want.status, want.pnode, want.ppri, want.best,
                     $sformatf("got st=%0d node=%0d pri=%0d best=%0d",
                        got.status, got.pnode, got.ppri, got.best));
            end
         end
      end
   end

   task automatic add_req(logic [1:0] op, logic [9:0] node, logic [11:0] pri);
      req_t r;
      r.op = op;
      r.node = node;
      r.pri = pri;
      pending_reqs.push_back(r);
   endtask

   // drain all queued beats and wait for all results
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_batch(int count);
      int k, pick;
      logic [9:0] nd;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         // small node pool keeps chains and repeats interesting
         nd = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(47));
         if (pick < 45)
            add_req(OP_PUSH, nd, ($urandom_range(19) == 0) ? 12'($urandom)
                    : 12'($urandom_range(15) * $urandom_range(16)));
         else if (pick < 70) add_req(OP_REMOVE, nd, 12'($urandom));
         else if (pick < 98) add_req(OP_POP, 10'($urandom), 12'($urandom));
         else add_req(OP_CLEAR, 10'($urandom), 12'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < NN; i++) begin
         q_open[i] = 0;
         q_next[i] = '0;
         q_bucket[i] = '0;
      end
      for (int i = 0; i < NB; i++) anc_valid[i] = 0;
      q_best = NB;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each op, each reject case
      add_req(OP_POP, 10'h3ff, 12'hfff);
      add_req(OP_REMOVE, 10'd5, 12'd0);
      add_req(OP_PUSH, 10'd0, 12'd0);
      add_req(OP_PUSH, 10'h3ff, 12'd255);
      add_req(OP_PUSH, 10'd7, 12'd256);
      add_req(OP_PUSH, 10'd7, 12'hfff);
      add_req(OP_PUSH, 10'd0, 12'd3);
      add_req(OP_PUSH, 10'd1, 12'd0);
      add_req(OP_PUSH, 10'd2, 12'd0);
      add_req(OP_PUSH, 10'd3, 12'd0);
      add_req(OP_REMOVE, 10'd0, 12'hfff);
      add_req(OP_REMOVE, 10'd2, 12'd0);
      add_req(OP_POP, 10'd0, 12'd0);
      add_req(OP_POP, 10'd0, 12'd0);
      add_req(OP_PUSH, 10'h2aa, 12'h0aa);
      add_req(OP_PUSH, 10'h155, 12'h055);
      add_req(OP_POP, 10'd0, 12'd0);
      add_req(OP_CLEAR, 10'h3ff, 12'hfff);
      add_req(OP_POP, 10'd0, 12'd0);
      add_req(OP_PUSH, 10'd9, 12'd128);
      add_req(OP_REMOVE, 10'd9, 12'd0);
      sending = 1;
      drain();

      // long receiver stall while the sender keeps offering
      random_batch(60);
      recv_hold = 400;
      drain();

      random_batch(600);
      drain();
      send_idle_pct = 56;
      recv_idle_pct = 15;
      random_batch(600);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_batch(570);
      drain();

      if (mismatches == 0)
         $display("tb_bucket_priority_queue_core: clean");
      else
         $display("tb_bucket_priority_queue_core: errors");
      $finish;
   end

   initial begin
      #60000000;
      $display("tb_bucket_priority_queue_core: errors");
      $finish;
   end

endmodule
